/* design/smm_pkg.sv */
// shared types and constants for the square matrix multiplier
`timescale 1ns / 1ps

package smm_pkg;

    localparam int MAX_SIZE_DEF = 16;   // default number of cells
    localparam int IDX_W        = 4;    // row and column index width
    localparam int SIZE_W       = 5;    // matrix size register width
    localparam int VAL_W        = 16;   // Q1.14 element width
    localparam int PROD_W       = 32;   // single product width
    localparam int ACC_W        = 36;   // accumulator width
    localparam int EMIT_LIM     = 16;   // largest size the index fields can address

    // word kinds carried in tuser
    localparam logic FUNC_STORE = 1'b0;
    localparam logic FUNC_LEFT  = 1'b1;

    // word travelling down the cell chain
    typedef struct packed {
        logic                    vld;
        logic                    func;
        logic                    fin;    // completes a row of the product
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] val;
    } t_tok;

endpackage

/* design/smm_cell.sv */
// one cell of the chain: a column of the right matrix and one accumulator
`timescale 1ns / 1ps

module smm_cell #(
    parameter int MAX_SIZE = smm_pkg::MAX_SIZE_DEF,
    parameter int CELL_IDX = 0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  smm_pkg::t_tok                    i_tok,
    input  logic [smm_pkg::SIZE_W-1:0]       i_n,
    input  logic                             i_shift,
    input  logic signed [smm_pkg::ACC_W-1:0] i_nbr_acc,
    output smm_pkg::t_tok                    o_tok,
    output logic signed [smm_pkg::ACC_W-1:0] o_acc,
    output logic                             o_done
);
    import smm_pkg::*;

    localparam int AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int EW = AW + IDX_W;
    localparam int CW = AW + IDX_W + 2;

    logic signed [VAL_W-1:0]  r_mem [MAX_SIZE];
    t_tok                     r_tok;
    logic signed [VAL_W-1:0]  r_a;
    logic signed [VAL_W-1:0]  r_b;
    logic                     r_mv;
    logic                     r_mfin;
    logic signed [PROD_W-1:0] r_p;
    logic                     r_pv;
    logic                     r_pfin;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;

    logic [EW-1:0] w_row_ext;
    logic [EW-1:0] w_col_ext;
    logic [AW-1:0] w_wr_addr;
    logic [AW-1:0] w_rd_addr;
    logic          w_wr_en;
    logic          w_active;    // cell index below the size in use
    logic          w_is_last;   // cell index is size minus one
    logic          w_tail;      // next cell is beyond the size in use

    assign w_row_ext = EW'(i_tok.row);
    assign w_col_ext = EW'(i_tok.col);
    assign w_wr_addr = w_row_ext[AW-1:0];
    assign w_rd_addr = w_col_ext[AW-1:0];

    assign w_wr_en = i_tok.vld && (i_tok.func == FUNC_STORE)
                  && (CW'(i_tok.col) == CW'(CELL_IDX))
                  && (CW'(i_tok.row) < CW'(MAX_SIZE));

    assign w_active  = CW'(CELL_IDX) < CW'(i_n);
    assign w_is_last = (CW'(CELL_IDX) + CW'(1)) == CW'(i_n);
    assign w_tail    = (CW'(CELL_IDX) + CW'(1)) >= CW'(i_n);

    // column store of the right matrix
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= i_tok.val;
        end
        r_b <= r_mem[w_rd_addr];
    end

    // token hop and multiply pipeline payload
    always_ff @(posedge i_clk) begin
        r_a <= i_tok.val;
        r_p <= r_a * r_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= '0;
            r_mv   <= 1'b0;
            r_mfin <= 1'b0;
            r_pv   <= 1'b0;
            r_pfin <= 1'b0;
            r_acc  <= '0;
        end else begin
            r_tok  <= i_tok;
            r_mv   <= i_tok.vld && (i_tok.func == FUNC_LEFT) && w_active;
            r_mfin <= i_tok.fin;
            r_pv   <= r_mv;
            r_pfin <= r_mfin;
            r_acc  <= n_acc;
        end
    end

    // accumulate, or shift toward the head while the row drains
    always_comb begin
        n_acc = r_acc;
        if (r_pv) begin
            n_acc = r_acc + ACC_W'(r_p);
        end else if (i_shift && w_active) begin
            n_acc = w_tail ? '0 : i_nbr_acc;
        end
    end

    assign o_tok  = r_tok;
    assign o_acc  = r_acc;
    assign o_done = r_pv && r_pfin && w_is_last;

endmodule

/* design/square_matrix_multiply.sv */
// top level of the square matrix multiplier: control, config port and cell chain
`timescale 1ns / 1ps

// Computes C = A x B for square matrices of size n (matrix_size register at
// byte address 0, reset 16, 0 counts as 1, capped at the smaller of 16 and
// MAX_SIZE). Send B first as words with tuser = 0, each carrying row, col and
// a Q1.14 value; then send rows of A with tuser = 1, columns in order. Every
// word travels down a chain of MAX_SIZE cells, one cell per cycle; cell j
// holds column j of B and the running sum for column j of the current C row.
// Store words and non-final A words are taken one per cycle. The A word with
// col = n-1 closes the row: input is held off while that word walks to cell
// n-1 and is summed there (one hop per cell plus the two-stage read/multiply
// inside the cell), then n output words of row C are shifted out of the chain
// head, one per cycle while m_tready is high, tlast on the last one; input
// resumes in the cycle after the last one is taken. A words with col >= n
// are taken and dropped. Sums are exact in 36-bit Q7.28 and wrap on overflow.
// Store entries never written read back undefined.
module square_matrix_multiply #(
    parameter int MAX_SIZE = smm_pkg::MAX_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // apb config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // row [3:0], col [7:4], value [23:8]
    input  logic        s_tuser,   // func
    // output words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_row [3:0], out_col [7:4], product [43:8], zeros
    output logic        m_tlast
);
    import smm_pkg::*;

    localparam int N_LIM = (MAX_SIZE < EMIT_LIM) ? MAX_SIZE : EMIT_LIM;

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_WAIT  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    localparam logic REG_SIZE = 1'b0;   // register index of matrix_size

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [SIZE_W-1:0] r_size;
    logic [SIZE_W-1:0] w_n;
    logic [IDX_W-1:0]  r_out_row;
    logic [IDX_W-1:0]  r_ecol;
    t_tok              r_tok;
    t_tok              n_tok;

    logic              w_in_acc;
    logic              w_out_acc;
    logic              w_cfg_wr;
    logic              w_last;
    logic              w_shift;

    logic [IDX_W-1:0]        w_row;
    logic [IDX_W-1:0]        w_col;
    logic signed [VAL_W-1:0] w_val;

    t_tok                    w_tok_in  [MAX_SIZE];
    t_tok                    w_tok_out [MAX_SIZE];
    logic signed [ACC_W-1:0] w_acc     [MAX_SIZE];
    logic signed [ACC_W-1:0] w_nbr     [MAX_SIZE];
    logic [MAX_SIZE-1:0]     w_done;

    // unpack the input word
    assign w_row = s_tdata[3:0];
    assign w_col = s_tdata[7:4];
    assign w_val = s_tdata[23:8];

    // config port, always ready
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SIZE);
    assign prdata   = (paddr[2] == REG_SIZE) ? 32'(r_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_W'(16);
        end else if (w_cfg_wr) begin
            r_size <= pwdata[SIZE_W-1:0];
        end
    end

    // effective size: zero counts as one, large values capped
    always_comb begin
        w_n = r_size;
        if (r_size == '0) begin
            w_n = SIZE_W'(1);
        end else if (r_size > SIZE_W'(N_LIM)) begin
            w_n = SIZE_W'(N_LIM);
        end
    end

    assign s_tready  = (r_state == ST_RUN);
    assign w_in_acc  = s_tvalid && s_tready;
    assign m_tvalid  = (r_state == ST_DRAIN);
    assign w_out_acc = m_tvalid && m_tready;
    assign w_last    = (SIZE_W'(r_ecol) + SIZE_W'(1)) == w_n;
    assign w_shift   = w_out_acc;

    // build the word that enters the chain; dropped A words inject nothing
    always_comb begin
        n_tok      = r_tok;
        n_tok.vld  = 1'b0;
        n_tok.fin  = 1'b0;
        n_state    = r_state;
        if (w_in_acc) begin
            n_tok.func = s_tuser;
            n_tok.row  = w_row;
            n_tok.col  = w_col;
            n_tok.val  = w_val;
            if (s_tuser == FUNC_STORE) begin
                n_tok.vld = 1'b1;
            end else if (SIZE_W'(w_col) < w_n) begin
                n_tok.vld = 1'b1;
                // last column closes the row
                if ((SIZE_W'(w_col) + SIZE_W'(1)) == w_n) begin
                    n_tok.fin = 1'b1;
                    n_state   = ST_WAIT;
                end
            end
        end
        case (r_state)
            ST_RUN: begin
            end
            ST_WAIT: begin
                if (|w_done) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_out_acc && w_last) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_tok   <= '0;
            r_ecol  <= '0;
        end else begin
            r_state <= n_state;
            r_tok   <= n_tok;
            if (w_out_acc) begin
                r_ecol <= w_last ? '0 : r_ecol + IDX_W'(1);
            end
        end
    end

    // row label comes from the word that completes the row
    always_ff @(posedge i_clk) begin
        if (n_tok.fin) begin
            r_out_row <= w_row;
        end
    end

    // the cell chain
    for (genvar j = 0; j < MAX_SIZE; j++) begin : g_cell
        if (j == 0) begin : g_head
            assign w_tok_in[j] = r_tok;
        end else begin : g_link
            assign w_tok_in[j] = w_tok_out[j-1];
        end
        if (j == MAX_SIZE - 1) begin : g_end
            assign w_nbr[j] = '0;
        end else begin : g_mid
            assign w_nbr[j] = w_acc[j+1];
        end

        smm_cell #(
            .MAX_SIZE (MAX_SIZE),
            .CELL_IDX (j)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_tok     (w_tok_in[j]),
            .i_n       (w_n),
            .i_shift   (w_shift),
            .i_nbr_acc (w_nbr[j]),
            .o_tok     (w_tok_out[j]),
            .o_acc     (w_acc[j]),
            .o_done    (w_done[j])
        );
    end

    // output word: chain head sum with its labels
    assign m_tdata = {4'b0000, w_acc[0], r_ecol, r_out_row};
    assign m_tlast = w_last;

`ifndef SYNTHESIS
    // a row can only finish while waiting for it
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_done) |-> (r_state == ST_WAIT))
        else $error("row completion outside wait state");

    // no new word enters the chain while a row drains
    a_chain_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (!r_tok.vld && !w_tok_out[0].vld))
        else $error("word in chain during drain");

    // the drained row leaves the head accumulator cleared
    a_head_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && m_tlast) |=> (w_acc[0] == '0))
        else $error("head accumulator not cleared after row");

    // labels hold while the head word is stalled
    a_col_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> $stable(r_ecol) && $stable(w_acc[0]))
        else $error("output word changed under stall");
`endif

endmodule

/* tb/smm_checker.sv */
// checker for the square matrix multiplier: predicts product words and compares them
`timescale 1ns / 1ps

module smm_checker #(
    parameter int         MAX_SIZE  = smm_pkg::MAX_SIZE_DEF,
    parameter logic [2:0] SIZE_ADDR = 3'd0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,   // row [3:0], col [7:4], value [23:8]
    input  logic        i_s_tuser,   // func
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [47:0] i_m_tdata,   // out_row [3:0], out_col [7:4], product [43:8], zeros
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending
);
    import smm_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [ACC_W-1:0] product;
        logic             last;
    } t_product_word;

    logic signed [VAL_W-1:0] right_store [MAX_SIZE][MAX_SIZE];
    logic [ACC_W-1:0]        col_sums [MAX_SIZE];
    logic [SIZE_W-1:0]       size_reg;
    t_product_word           expected_products [$];
    int                      fails;
    int                      r;
    int                      c;

    // size in use: zero counts as one, large values saturate
    function automatic int active_size();
        int n;
        n = int'(size_reg);
        if (n < 1) n = 1;
        if (n > EMIT_LIM) n = EMIT_LIM;
        if (n > MAX_SIZE) n = MAX_SIZE;
        return n;
    endfunction

    task automatic accumulate_word(input logic func, input logic [IDX_W-1:0] row,
                                   input logic [IDX_W-1:0] col,
                                   input logic signed [VAL_W-1:0] value);
        int                        n;
        int                        j;
        logic signed [2*VAL_W-1:0] term;
        t_product_word             w;
        n = active_size();
        if (func == FUNC_STORE) begin
            if (row < MAX_SIZE && col < MAX_SIZE)
                right_store[row][col] = value;
        end else if (col < n) begin
            for (j = 0; j < n; j++) begin
                term = value * right_store[col][j];
                col_sums[j] = col_sums[j] + {{(ACC_W-2*VAL_W){term[2*VAL_W-1]}}, term};
            end
            if (col == n - 1) begin
                for (j = 0; j < n; j++) begin
                    w.row     = row;
                    w.col     = j[IDX_W-1:0];
                    w.product = col_sums[j];
                    w.last    = (j == n - 1);
                    expected_products = {expected_products, w};
                    col_sums[j] = '0;
                end
            end
        end
    endtask

    task automatic compare_word();
        t_product_word got;
        t_product_word want;
        got.row     = i_m_tdata[3:0];
        got.col     = i_m_tdata[7:4];
        got.product = i_m_tdata[43:8];
        got.last    = i_m_tlast;
        if (expected_products.size() == 0) begin
            fails++;
            $display("%0t: unexpected product word: row %0d col %0d product %0d last %b",
                     $time, got.row, got.col, $signed(got.product), got.last);
        end else begin
            want = expected_products.pop_front();
            if (got.row !== want.row || got.col !== want.col ||
                got.product !== want.product || got.last !== want.last) begin
                fails++;
                $display("%0t: expected row %0d col %0d product %0d last %b, got row %0d col %0d product %0d last %b",
                         $time, want.row, want.col, $signed(want.product), want.last,
                         got.row, got.col, $signed(got.product), got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (r = 0; r < MAX_SIZE; r++) begin
                col_sums[r] = '0;
                for (c = 0; c < MAX_SIZE; c++)
                    right_store[r][c] = '0;
            end
            size_reg = SIZE_W'(EMIT_LIM);
            fails    = 0;
            expected_products.delete();
        end else begin
            // outputs first: a word taken now cannot stem from an input taken now
            if (i_m_tvalid && i_m_tready)
                compare_word();
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == SIZE_ADDR)
                size_reg = i_pwdata[SIZE_W-1:0];
            if (i_s_tvalid && i_s_tready)
                accumulate_word(i_s_tuser, i_s_tdata[3:0], i_s_tdata[7:4], i_s_tdata[23:8]);
        end
        o_fail_count = fails;
        o_pending    = expected_products.size();
    end

endmodule

/* tb/tb.sv */
// testbench top for the square matrix multiplier: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb;
    import smm_pkg::*;

    localparam logic [2:0] REG_MATRIX_SIZE = 3'd0;
    localparam int         ITEM_TARGET     = 350;              // input words that drive the stop
    localparam int         SETTLE_CYCLES   = MAX_SIZE_DEF + 8; // chain length plus margin

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // row [3:0], col [7:4], value [23:8]
    logic        s_tuser;   // func
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // out_row [3:0], out_col [7:4], product [43:8], zeros
    logic        m_tlast;
    int          fail_count;
    int          pending;

    // stimulus bookkeeping
    bit          store_written [EMIT_LIM][EMIT_LIM];
    int          words_taken;
    int          cur_size;
    int          send_quiet;
    bit          calm;

    square_matrix_multiply dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    smm_checker #(
        .SIZE_ADDR (REG_MATRIX_SIZE)
    ) product_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // hard stop well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("square_matrix_multiply: mismatch");
        $finish;
    end

    // element values lean toward the extremes of Q1.14
    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // one word on the input stream, with an occasional gap in front of it
    task automatic send_word(input logic func, input logic [3:0] row,
                             input logic [3:0] col, input logic [15:0] value);
        int gap;
        gap = 0;
        if (!calm) begin
            if (send_quiet > 0)
                send_quiet--;
            else if ($urandom_range(0, 59) == 0)
                send_quiet = $urandom_range(20, 60);
            else if ($urandom_range(0, 4) == 0)
                gap = $urandom_range(1, 8);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {value, col, row};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        words_taken++;
        // the last stretch of the run goes without idling
        if (words_taken > ITEM_TARGET * 85 / 100)
            calm = 1'b1;
        if (func == FUNC_STORE)
            store_written[row][col] = 1'b1;
    endtask

    // drain every product word, then let the cell chain empty out
    task automatic wait_idle();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // matrix size register write over apb, only with the block idle
    task automatic write_size(input logic [4:0] size_code);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_MATRIX_SIZE;
        pwdata  <= {27'd0, size_code};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (size_code == 0)
            cur_size = 1;
        else if (size_code > EMIT_LIM)
            cur_size = EMIT_LIM;
        else
            cur_size = int'(size_code);
    endtask

    // every store entry a left word of this size can read must hold data first
    task automatic fill_store(input int n);
        int r;
        int c;
        for (r = 0; r < n; r++)
            for (c = 0; c < n; c++)
                if (!store_written[r][c])
                    send_word(FUNC_STORE, 4'(r), 4'(c), pick_value());
    endtask

    // one row of A: mostly clean, sometimes with stray or broken words
    task automatic send_row(input int n, input bit complete);
        logic [3:0] label;
        int         kind;
        int         stop;
        int         k;
        label = 4'($urandom_range(0, 15));
        kind  = $urandom_range(0, 9);
        stop  = complete ? n : $urandom_range(1, n - 1);
        if (kind == 0) begin
            // scattered columns anywhere in the field, may or may not close the row
            repeat ($urandom_range(1, n + 2))
                send_word(FUNC_LEFT, label, 4'($urandom_range(0, 15)), pick_value());
        end else begin
            for (k = 0; k < stop; k++) begin
                if (kind == 1 && k == stop / 2) begin
                    // store update mid-row, then a dropped column or a repeated one
                    send_word(FUNC_STORE, 4'($urandom_range(0, 15)),
                              4'($urandom_range(0, 15)), pick_value());
                    if (n < EMIT_LIM)
                        send_word(FUNC_LEFT, label, 4'($urandom_range(n, 15)), pick_value());
                    else
                        send_word(FUNC_LEFT, label, 4'(k), pick_value());
                end
                send_word(FUNC_LEFT, label, 4'(k), pick_value());
            end
        end
    endtask

    // receiver: stall bursts, quiet stretches, none near the end
    initial begin
        int stall_left;
        int quiet_left;
        stall_left = 0;
        quiet_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (calm || quiet_left > 0) begin
                m_tready <= 1'b1;
                if (quiet_left > 0)
                    quiet_left--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 79) == 0) begin
                quiet_left = $urandom_range(20, 60);
                m_tready <= 1'b1;
            end else if ($urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 7);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // main stimulus and verdict
    initial begin
        logic [4:0] opening_sizes [4];
        logic [4:0] size_code;
        int         phase;
        int         n;
        opening_sizes = '{5'd1, 5'd5, 5'd0, 5'd31};
        i_rst_n     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = FUNC_STORE;
        words_taken = 0;
        send_quiet  = 0;
        calm        = 1'b0;
        cur_size    = EMIT_LIM;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at size 2: extreme values and indexes
        write_size(5'd2);
        send_word(FUNC_STORE, 4'd0, 4'd0, 16'h8000);
        send_word(FUNC_STORE, 4'd0, 4'd1, 16'h7fff);
        send_word(FUNC_STORE, 4'd1, 4'd0, 16'h7fff);
        send_word(FUNC_STORE, 4'd1, 4'd1, 16'h8000);
        send_word(FUNC_STORE, 4'd15, 4'd15, 16'h5555);
        send_word(FUNC_STORE, 4'd15, 4'd0, 16'haaaa);
        send_word(FUNC_STORE, 4'd0, 4'd15, 16'h0000);
        // most negative squared, then most positive
        send_word(FUNC_LEFT, 4'd15, 4'd0, 16'h8000);
        send_word(FUNC_LEFT, 4'd15, 4'd1, 16'h8000);
        send_word(FUNC_LEFT, 4'd0, 4'd0, 16'h7fff);
        send_word(FUNC_LEFT, 4'd0, 4'd1, 16'h7fff);
        // columns past the size are dropped
        send_word(FUNC_LEFT, 4'd3, 4'd9, 16'hffff);
        send_word(FUNC_LEFT, 4'd3, 4'd15, 16'h7fff);
        // missing and repeated columns
        send_word(FUNC_LEFT, 4'd5, 4'd1, 16'h0001);
        send_word(FUNC_LEFT, 4'd6, 4'd0, 16'd100);
        send_word(FUNC_LEFT, 4'd6, 4'd0, 16'hfff9);
        send_word(FUNC_LEFT, 4'd6, 4'd1, 16'd3);
        // store rewrite in the middle of a row
        send_word(FUNC_LEFT, 4'd2, 4'd0, 16'd1000);
        send_word(FUNC_STORE, 4'd1, 4'd1, 16'd12345);
        send_word(FUNC_LEFT, 4'd2, 4'd1, 16'hffff);
        // size change mid-row: sums carry over, zero size counts as one
        send_word(FUNC_LEFT, 4'd9, 4'd0, 16'h8000);
        write_size(5'd0);
        send_word(FUNC_LEFT, 4'd10, 4'd0, 16'h7fff);
        send_word(FUNC_LEFT, 4'd10, 4'd1, 16'd5);

        // sums that wrap around the 36-bit range
        write_size(5'd2);
        send_word(FUNC_STORE, 4'd0, 4'd0, 16'h8000);
        send_word(FUNC_STORE, 4'd0, 4'd1, 16'h8000);
        repeat (36) send_word(FUNC_LEFT, 4'd7, 4'd0, 16'h8000);
        send_word(FUNC_LEFT, 4'd7, 4'd1, 16'h0000);

        // random phases, mostly small sizes, a few at full size
        phase = 0;
        while (words_taken < ITEM_TARGET) begin
            if (phase < 4)
                size_code = opening_sizes[phase];
            else if ($urandom_range(0, 5) == 0)
                size_code = 5'($urandom_range(0, 31));
            else
                size_code = 5'($urandom_range(0, 9));
            write_size(size_code);
            n = cur_size;
            fill_store(n);
            repeat ($urandom_range(0, 3))
                send_word(FUNC_STORE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                          pick_value());
            repeat ((n >= 12) ? $urandom_range(1, 2) : $urandom_range(1, 6))
                send_row(n, 1'b1);
            // a row left open across the next size change
            if (n >= 2 && $urandom_range(0, 3) == 0)
                send_row(n, 1'b0);
            phase++;
        end

        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("square_matrix_multiply: match");
        else
            $display("square_matrix_multiply: mismatch");
        $finish;
    end

endmodule
